@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/klp_pkg.sv @@
// Types and constants of the key/value line parser.
// No dependencies; used by key_value_line_parser.
package klp_pkg;

  // Width of the internal offset counter; it saturates at all ones.
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned OffsetOutBits = 16;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    PHASE_KEY   = 2'd0,
    PHASE_SKIP  = 2'd1,
    PHASE_VALUE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_KEY      = 3'd0,
    ROLE_KEY_END  = 3'd1,
    ROLE_SPACE    = 3'd2,
    ROLE_VALUE    = 3'd3,
    ROLE_PAIR_END = 3'd4,
    ROLE_STOP     = 3'd5,
    ROLE_IGNORED  = 3'd6
  } role_e;

  typedef enum logic [1:0] {
    STATUS_RUNNING   = 2'd0,
    STATUS_COMPLETE  = 2'd1,
    STATUS_STOPPED   = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_e;

  typedef logic [OffsetBits-1:0] pos_t;

endpackage

@@ rtl/key_value_line_parser.sv @@
// Key/value line parser: tags each byte of a buffer with its role and offset.
// Depends on klp_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one buffer byte per
//   transaction, with last_byte_i marking the final byte of the buffer.
//   Output channel (out_valid_o / out_ready_i) carries exactly one result per
//   input byte: role_o, offset_o (saturating byte position) and status_o.
//   A byte's result is registered and presented in the cycle after its input
//   transaction. Throughput: one byte per cycle unless the receiver stalls;
//   the phase logic sits between the input handshake and one result register.
//   A new byte is taken while the result register is empty or is being
//   drained in the same cycle, so a stalled receiver holds at most one
//   result and stops the input only while that result waits.
//   After the last byte of a buffer the phase, offset counter and stop flag
//   return to their reset values, so the next byte opens a new buffer.
//   Reset (rst_ni low, asynchronous) empties the result register and puts
//   the parser in the key phase at offset zero.
`include "assert_macros.svh"

module key_value_line_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] role_o,
  output logic [klp_pkg::OffsetOutBits-1:0] offset_o,
  output logic [1:0] status_o
);

  klp_pkg::phase_e  phase_q, phase_d;
  klp_pkg::pos_t    pos_q, pos_d;
  logic             stop_q, stop_d;

  logic             out_valid_q;
  klp_pkg::role_e   role_q, role_d;
  klp_pkg::status_e status_q, status_d;
  logic [klp_pkg::OffsetOutBits-1:0] offset_q, offset_d;

  logic             in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    stop_d   = stop_q;
    pos_d    = pos_q;
    role_d   = klp_pkg::ROLE_IGNORED;
    status_d = klp_pkg::STATUS_RUNNING;
    offset_d = klp_pkg::OffsetOutBits'(pos_q);

    if (stop_q) begin
      role_d = klp_pkg::ROLE_IGNORED;
    end else begin
      unique case (phase_q)
        klp_pkg::PHASE_SKIP, klp_pkg::PHASE_VALUE: begin
          if (byte_value_i == klp_pkg::ChNewline) begin
            role_d  = klp_pkg::ROLE_PAIR_END;
            phase_d = klp_pkg::PHASE_KEY;
          end else if (phase_q == klp_pkg::PHASE_SKIP &&
                       byte_value_i == klp_pkg::ChSpace) begin
            role_d = klp_pkg::ROLE_SPACE;
          end else begin
            role_d  = klp_pkg::ROLE_VALUE;
            phase_d = klp_pkg::PHASE_VALUE;
          end
        end
        default: begin
          // key phase; the unused phase code behaves the same
          if (byte_value_i == klp_pkg::ChColon) begin
            role_d  = klp_pkg::ROLE_KEY_END;
            phase_d = klp_pkg::PHASE_SKIP;
          end else if (byte_value_i == klp_pkg::ChNewline) begin
            role_d   = klp_pkg::ROLE_STOP;
            stop_d   = 1'b1;
            status_d = klp_pkg::STATUS_STOPPED;
          end else begin
            role_d = klp_pkg::ROLE_KEY;
          end
        end
      endcase
    end

    if (last_byte_i) begin
      if (stop_d) begin
        status_d = klp_pkg::STATUS_STOPPED;
      end else if (role_d == klp_pkg::ROLE_PAIR_END) begin
        status_d = klp_pkg::STATUS_COMPLETE;
      end else begin
        status_d = klp_pkg::STATUS_TRUNCATED;
      end
    end

    if (pos_q != '1) begin
      pos_d = pos_q + klp_pkg::pos_t'(1);
    end

    if (last_byte_i) begin
      phase_d = klp_pkg::PHASE_KEY;
      stop_d  = 1'b0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= klp_pkg::PHASE_KEY;
      stop_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        stop_q      <= stop_d;
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      role_q   <= role_d;
      status_q <= status_d;
      offset_q <= offset_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign role_o      = role_q;
  assign offset_o    = offset_q;
  assign status_o    = status_q;

  // a stopped parse only leaves the key phase through a new buffer
  `ASSERT_PROP(a_stop_in_key_phase, clk_i, rst_ni,
               stop_q |-> phase_q == klp_pkg::PHASE_KEY)
  `ASSERT_PROP(a_last_resets_state, clk_i, rst_ni,
               in_fire && last_byte_i |=> pos_q == '0 && !stop_q &&
               phase_q == klp_pkg::PHASE_KEY)
  `ASSERT_PROP(a_stop_reports_stopped, clk_i, rst_ni,
               out_valid_q && role_q == klp_pkg::ROLE_STOP |->
               status_q == klp_pkg::STATUS_STOPPED)
  `ASSERT_NEVER(a_complete_needs_pair_end, clk_i, rst_ni,
                out_valid_q && status_q == klp_pkg::STATUS_COMPLETE &&
                role_q != klp_pkg::ROLE_PAIR_END)

endmodule

@@ sim/kv_line_check.sv @@
// Scoreboard for key_value_line_parser: predicts role, offset and status per byte
// and checks each result transaction. Depends on klp_pkg.
`timescale 1ns / 1ps

module kv_line_check
  import klp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  role_i,
  input  logic [15:0] offset_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int MaxReports = 200;

  typedef struct packed {
    role_e                    role;
    logic [OffsetOutBits-1:0] offset;
    status_e                  status;
  } byte_tag_t;

  // Parser state as the block should hold it
  phase_e parse_phase;
  pos_t   next_pos;
  logic   stop_seen;

  byte_tag_t tag_q[$];
  int        reports = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic tag_byte(input logic [7:0] b, input logic last, output byte_tag_t tag);
    role_e   role;
    status_e status;
    begin
      status = STATUS_RUNNING;
      tag.offset = OffsetOutBits'(next_pos);
      if (stop_seen) begin
        role = ROLE_IGNORED;
      end else if (parse_phase == PHASE_SKIP || parse_phase == PHASE_VALUE) begin
        if (b == ChNewline) begin
          role = ROLE_PAIR_END;
          parse_phase = PHASE_KEY;
        end else if (parse_phase == PHASE_SKIP && b == ChSpace) begin
          role = ROLE_SPACE;
        end else begin
          role = ROLE_VALUE;
          parse_phase = PHASE_VALUE;
        end
      end else if (b == ChColon) begin
        role = ROLE_KEY_END;
        parse_phase = PHASE_SKIP;
      end else if (b == ChNewline) begin
        // newline inside a key ends the parse for this buffer
        role = ROLE_STOP;
        stop_seen = 1'b1;
        status = STATUS_STOPPED;
      end else begin
        role = ROLE_KEY;
      end

      if (last) begin
        if (stop_seen) status = STATUS_STOPPED;
        else if (role == ROLE_PAIR_END) status = STATUS_COMPLETE;
        else status = STATUS_TRUNCATED;
      end

      if (next_pos != {OffsetBits{1'b1}}) next_pos = next_pos + 1'b1;

      if (last) begin
        parse_phase = PHASE_KEY;
        next_pos = '0;
        stop_seen = 1'b0;
      end
      tag.role = role;
      tag.status = status;
    end
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    begin
      fail_count_o = fail_count_o + 1;
      if (reports < MaxReports) begin
        reports = reports + 1;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    byte_tag_t want;
    if (!rst_ni) begin
      parse_phase = PHASE_KEY;
      next_pos = '0;
      stop_seen = 1'b0;
      tag_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        tag_byte(byte_value_i, last_byte_i, want);
        tag_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (tag_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (reports < MaxReports) begin
            reports = reports + 1;
            $display({"%0t: result with no byte pending: expected none, ",
                      "actual role %0d offset %0d status %0d"},
                     $time, role_i, offset_i, status_i);
          end
        end else begin
          want = tag_q.pop_front();
          if (role_i !== want.role) report_field("role", want.role, role_i);
          if (offset_i !== want.offset) report_field("offset", want.offset, offset_i);
          if (status_i !== want.status) report_field("status", want.status, status_i);
        end
      end
    end
    pending_o = tag_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the key_value_line_parser testbench: clock, reset, byte stimulus and verdict.
// Depends on klp_pkg, key_value_line_parser and kv_line_check.
`timescale 1ns / 1ps

module tb_top;
  import klp_pkg::*;

  localparam int CycleLimit = 100_000;
  localparam int RandomBytes = 1200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  role;
  logic [15:0] offset;
  logic [1:0]  status;
  int          fail_count;
  int          pending;

  logic        jitter = 1'b1;
  int          cycles = 0;
  logic [7:0]  frame_q[$];
  int          tail_ignored;
  int          live_bytes = 0;

  always #4 clk = ~clk;

  key_value_line_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .byte_value_i(byte_value),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .role_o      (role),
    .offset_o    (offset),
    .status_o    (status)
  );

  kv_line_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .byte_value_i(byte_value),
    .last_byte_i (last_byte),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .role_i      (role),
    .offset_i    (offset),
    .status_i    (status),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk) begin
    out_ready <= !(jitter && $urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Returns right after the edge that accepted the transaction; valid stays up.
  task automatic send_byte(input logic [7:0] b, input logic last);
    begin
      @(negedge clk);
      while (jitter && $urandom_range(99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      byte_value <= b;
      last_byte <= last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    begin
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Drop valid and hold off until every result is back.
  task automatic drain();
    begin
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = ChColon;
      1: b = ChNewline;
      2: b = ChSpace;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_byte();
    logic [7:0] b;
    b = any_byte();
    while (b == ChColon || b == ChNewline) b = any_byte();
    return b;
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    b = any_byte();
    while (b == ChNewline) b = any_byte();
    return b;
  endfunction

  // Mostly well-formed lines, then an ending that completes, truncates, stops or is noise.
  task automatic fill_frame();
    int lines;
    int ending;
    begin
      frame_q.delete();
      tail_ignored = 0;
      lines = $urandom_range(4);
      repeat (lines) begin
        repeat ($urandom_range(6)) frame_q.push_back(key_byte());
        frame_q.push_back(ChColon);
        repeat ($urandom_range(3)) frame_q.push_back(ChSpace);
        repeat ($urandom_range(8)) frame_q.push_back(value_byte());
        frame_q.push_back(ChNewline);
      end
      ending = $urandom_range(9);
      if (ending == 5 || ending == 6) begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(key_byte());
        if ($urandom_range(1)) begin
          frame_q.push_back(ChColon);
          repeat ($urandom_range(3)) frame_q.push_back(value_byte());
        end
      end else if (ending == 7 || ending == 8) begin
        repeat ($urandom_range(3)) frame_q.push_back(key_byte());
        frame_q.push_back(ChNewline);
        tail_ignored = $urandom_range(6);
        repeat (tail_ignored) frame_q.push_back(any_byte());
      end else if (ending == 9) begin
        repeat ($urandom_range(1, 12)) frame_q.push_back(any_byte());
      end
      if (frame_q.size() == 0) frame_q.push_back(any_byte());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // colon as first value byte, colon inside the value, complete buffer
    send_text("A:  :x:\n");
    // empty key, empty values after colon and after spaces, truncated end
    send_text(":\nb: \nz");
    // stop in a key, then ignored bytes up to the last one
    send_byte("q", 1'b0);
    send_byte(ChNewline, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // single-byte buffers: stop on the last byte, truncated key
    send_byte(ChNewline, 1'b1);
    send_byte(8'h00, 1'b1);
    // truncated inside a value
    send_byte(8'hFF, 1'b0);
    send_byte(ChColon, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    while (live_bytes < RandomBytes) begin
      jitter = !(live_bytes >= 300 && live_bytes < 700);
      fill_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      live_bytes += frame_q.size() - tail_ignored;
    end
    jitter = 1'b1;
    drain();

    send_text("x:\n");

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
